// ----- design/wbps_pkg.sv -----
// wbps_pkg: shared types and constants of the wildcard byte pattern search unit
// used by the channel interfaces and by the top level; no dependencies

package wbps_pkg;

  // fixed field widths
  localparam int DATA_W    = 8;
  localparam int OUT_OFF_W = 32;
  localparam int CFG_W     = 64;
  localparam int MASK_W    = 16;
  localparam int LEN_W     = 5;
  localparam int IDX_W     = 2;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PAT_LO = 2'd0,
    REG_PAT_HI = 2'd1,
    REG_WILD   = 2'd2,
    REG_PLEN   = 2'd3
  } wbps_reg_t;

endpackage

// ----- design/wbps_if.sv -----
// wbps_if: valid/ready channel interfaces for image bytes and search results
// depends on wbps_pkg for field widths

interface wbps_in_if import wbps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [OUT_OFF_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ----- design/wildcard_byte_pattern_search_unit.sv -----
// an accepted byte is held in the input register, its result (if any) in the
// result register; one byte per cycle unless the output stalls; registers
// around one stage of window shift and parallel masked compare, no internal stalls
// reset (rst_n, synchronous, active low): window, byte count and match flag clear,
// pattern registers clear, pattern length goes to 1; the block is ready at once
// depends on wbps_pkg and the channel interfaces in wbps_if

module wildcard_byte_pattern_search_unit import wbps_pkg::*; #(
  parameter int PATTERN_MAX  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  wbps_in_if.sink               in_ch,
  wbps_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int WIN_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // configuration registers
  logic [CFG_W-1:0]  pat_lo_r;
  logic [CFG_W-1:0]  pat_hi_r;
  logic [MASK_W-1:0] wild_r;
  logic [LEN_W-1:0]  plen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      wild_r   <= '0;
      plen_r   <= LEN_W'(1);
    end else if (cfg_we) begin
      case (wbps_reg_t'(cfg_index))
        REG_PAT_LO: pat_lo_r <= cfg_wdata;
        REG_PAT_HI: pat_hi_r <= cfg_wdata;
        REG_WILD:   wild_r   <= cfg_wdata[MASK_W-1:0];
        REG_PLEN:   plen_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [2*CFG_W-1:0] pat_all;
  assign pat_all = {pat_hi_r, pat_lo_r};

  // active pattern length, clamped to 1..PATTERN_MAX
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_m1;
  always_comb begin
    if (plen_r == '0) begin
      len = LEN_W'(1);
    end else if (plen_r > LEN_W'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = plen_r;
    end
    len_m1 = len - LEN_W'(1);
  end

  // handshake control
  logic              s1_v_r;
  logic [DATA_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              out_v_r;
  logic              found_r;
  logic [OUT_OFF_W-1:0] offset_r;
  logic              out_free;
  logic              proc;

  assign out_free     = !out_v_r || out_ch.ready;
  assign proc         = s1_v_r && out_free;
  assign in_ch.ready  = !s1_v_r || proc;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  // image state
  logic [DATA_W-1:0]       window_r [PATTERN_MAX];
  logic [DATA_W-1:0]       win_new  [PATTERN_MAX];
  logic [OFFSET_WIDTH-1:0] seen_r;
  logic                    rep_r;

  // window after shifting in the current byte, entry 0 newest
  assign win_new[0] = s1_byte_r;
  for (genvar i = 1; i < PATTERN_MAX; i++) begin : g_shift
    assign win_new[i] = window_r[i-1];
  end

  // parallel masked compare, pattern byte k against the byte len-1-k back
  logic [PATTERN_MAX-1:0] pos_ok;
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cmp
    logic [LEN_W-1:0] pos_k;
    assign pos_k     = len_m1 - LEN_W'(k);
    assign pos_ok[k] = (LEN_W'(k) >= len) || wild_r[k] ||
                       (win_new[pos_k[WIN_IDX_W-1:0]] == pat_all[DATA_W*k +: DATA_W]);
  end

  // byte count, match test and offset
  logic                    sat;
  logic [OFFSET_WIDTH-1:0] seen_nxt;
  logic                    enough;
  logic                    hit;
  logic                    emit;
  logic [OFFSET_WIDTH-1:0] off_full;
  logic [OUT_OFF_W-1:0]    off_out;

  assign sat      = &seen_r;
  assign seen_nxt = sat ? seen_r : seen_r + OFFSET_WIDTH'(1);
  assign enough   = sat || (seen_r >= OFFSET_WIDTH'(len_m1));
  assign off_full = seen_r - OFFSET_WIDTH'(sat ? len : len_m1);
  assign hit      = !rep_r && enough && (&pos_ok);
  assign emit     = hit || (s1_last_r && !rep_r);

  // offset fitted to the output field
  if (OFFSET_WIDTH > OUT_OFF_W) begin : g_off_sat
    assign off_out = (|off_full[OFFSET_WIDTH-1:OUT_OFF_W]) ? '1 : off_full[OUT_OFF_W-1:0];
  end else begin : g_off_ext
    assign off_out = OUT_OFF_W'(off_full);
  end

  // state update, cleared after the last byte of an image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '{default: '0};
      seen_r   <= '0;
      rep_r    <= 1'b0;
    end else if (proc) begin
      if (s1_last_r) begin
        window_r <= '{default: '0};
        seen_r   <= '0;
        rep_r    <= 1'b0;
      end else begin
        window_r <= win_new;
        seen_r   <= seen_nxt;
        rep_r    <= rep_r || hit;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= proc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      found_r  <= hit;
      offset_r <= hit ? off_out : '0;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.found        = found_r;
  assign out_ch.match_offset = offset_r;

  // a not-found result always carries a zero offset
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !found_r |-> offset_r == '0)
    else $error("not-found result with nonzero offset");

  // the last byte of an image leaves the image state cleared
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r |=> seen_r == '0 && !rep_r)
    else $error("image state not cleared after last byte");

  // a reported match marks the image as done unless it ended there
  a_hit_marks: assert property (@(posedge clk) disable iff (!rst_n)
    proc && hit && !s1_last_r |=> rep_r)
    else $error("match not recorded");

  // once a match was reported, no further result for that image
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && rep_r |=> !out_v_r)
    else $error("second result for one image");

endmodule
